>>> hdl/coincidence_sorter_macros.svh
// Assertion macros shared by the coincidence sorter RTL.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef COINCIDENCE_SORTER_MACROS_SVH
`define COINCIDENCE_SORTER_MACROS_SVH

`ifndef SYNTHESIS
`define CS_ASSERT_ALWAYS(lbl, ck, rn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) else $error(msg);
`define CS_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);
`else
`define CS_ASSERT_ALWAYS(lbl, ck, rn, cond, msg)
`define CS_ASSERT_IMPLY(lbl, ck, rn, ante, cons, msg)
`endif

`endif

>>> hdl/csort_pkg.sv
// Shared types and constants of the coincidence sorter.
// Used by the channel interfaces, the front, the back and the top level.
package csort_pkg;

  localparam int WINDOW_DEPTH = 5;
  localparam int WIN_HELD     = WINDOW_DEPTH - 1;
  localparam int FILL_W       = 3;
  localparam int TIME_W       = 32;
  localparam int EVENT_W      = 32;
  localparam int CH_W         = 4;
  localparam int RD_W         = 32;
  localparam int CW_W         = 16;
  localparam int CIU_W        = 5;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;
  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 4;
  localparam int BACKLOG_W    = 3;

  localparam logic [CW_W-1:0]  CW_RESET  = 16'd2;
  localparam logic [CIU_W-1:0] CIU_RESET = 5'd16;

  localparam logic REG_WINDOW   = 1'b0;
  localparam logic REG_CHANNELS = 1'b1;

  localparam logic KIND_HIT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [CH_W-1:0] TOT_DOUBLE   = 4'd0;
  localparam logic [CH_W-1:0] TOT_TRUE     = 4'd1;
  localparam logic [CH_W-1:0] TOT_MULTIPLE = 4'd2;

  typedef enum logic [1:0] {
    TBL_HITS   = 2'd0,
    TBL_DOUBLE = 2'd1,
    TBL_TRUE   = 2'd2,
    TBL_TOTALS = 2'd3
  } table_sel_t;

  typedef struct packed {
    logic            kind;
    logic            full;
    logic            dbl;
    logic            tru;
    logic            mult;
    logic            pair_ok;
    logic            count_hit;
    logic            rd_ok;
    logic [CH_W-1:0] ch;
    logic [CH_W-1:0] a;
    logic [CH_W-1:0] b;
    table_sel_t      sel;
    logic [CH_W-1:0] row;
    logic [CH_W-1:0] col;
  } item_t;

  typedef struct packed {
    logic            window_full;
    logic            double_found;
    logic            true_found;
    logic            multiple_found;
    logic [CH_W-1:0] pair_first;
    logic [CH_W-1:0] pair_second;
    logic [RD_W-1:0] read_value;
  } result_t;

  typedef struct packed {
    logic                 clearing;
    logic [BACKLOG_W-1:0] backlog;
  } back_status_t;

endpackage

>>> hdl/csort_ifs.sv
// Valid/ready channel interfaces for the sorter's input items and results.
// Depends on csort_pkg for field widths.
interface csort_in_if import csort_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [TIME_W-1:0] hit_time;
  logic [CH_W-1:0]   hit_channel;
  logic [EVENT_W-1:0] hit_event;
  logic [1:0]        table_select;
  logic [CH_W-1:0]   read_row;
  logic [CH_W-1:0]   read_col;

  modport source (output valid, kind, hit_time, hit_channel, hit_event, table_select,
                  read_row, read_col, input ready);
  modport sink (input valid, kind, hit_time, hit_channel, hit_event, table_select,
                read_row, read_col, output ready);
endinterface

interface csort_out_if import csort_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            window_full;
  logic            double_found;
  logic            true_found;
  logic            multiple_found;
  logic [CH_W-1:0] pair_first;
  logic [CH_W-1:0] pair_second;
  logic [RD_W-1:0] read_value;

  modport source (output valid, window_full, double_found, true_found, multiple_found,
                  pair_first, pair_second, read_value, input ready);
  modport sink (input valid, window_full, double_found, true_found, multiple_found,
                pair_first, pair_second, read_value, output ready);
endinterface

>>> hdl/csort_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; a read of the address being written returns the old data.
module csort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/csort_fifo.sv
// Small synchronous FIFO used as the front-to-back queue and the result buffer.
// Element type and depth are parameters; no package dependency.
module csort_fifo #(
  parameter type elem_t = logic,
  parameter int  DEPTH  = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  elem_t                      din,
  input  logic                       pop,
  output elem_t                      dout,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  elem_t         mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  assign dout  = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

>>> hdl/csort_front.sv
// Front end: accepts items, keeps the hit window and classifies each hit.
// Depends on csort_pkg and csort_in_if; feeds the item queue.
module csort_front import csort_pkg::*; #(
  parameter int MAX_CHANNELS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  csort_in_if.sink         in_ch,
  input  logic [CW_W-1:0]  coinc_window,
  input  logic [CIU_W-1:0] chan_in_use,
  input  logic             q_full,
  input  logic             clearing,
  output logic             q_push,
  output item_t            q_item
);

  localparam int AW = ($clog2(MAX_CHANNELS + 1) > CIU_W) ? $clog2(MAX_CHANNELS + 1) : CIU_W;

  logic [FILL_W-1:0]  fill_r;
  logic [TIME_W-1:0]  time_r  [WIN_HELD];
  logic [CH_W-1:0]    chan_r  [WIN_HELD];
  logic [EVENT_W-1:0] event_r [WIN_HELD];

  logic          accept, is_hit, full;
  logic [3:0]    g;
  logic [AW-1:0] act;
  logic          row_ok, col_ok, dbl;
  table_sel_t    sel;

  function automatic logic gap_open(input logic [TIME_W-1:0] e, input logic [TIME_W-1:0] l,
                                    input logic [CW_W-1:0] w);
    logic [TIME_W-1:0] d;
    d = l - e;
    return (l > e) && (d > TIME_W'(w));
  endfunction

  assign in_ch.ready = !q_full && !clearing;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_push      = accept;
  assign is_hit      = (in_ch.kind == KIND_HIT);
  assign full        = (fill_r >= FILL_W'(WIN_HELD));
  assign sel         = table_sel_t'(in_ch.table_select);

  always_comb begin
    for (int i = 0; i < WIN_HELD - 1; i++) begin
      g[i] = gap_open(time_r[i], time_r[i+1], coinc_window);
    end
    g[3] = gap_open(time_r[WIN_HELD-1], in_ch.hit_time, coinc_window);
  end

  assign act    = (AW'(chan_in_use) > AW'(MAX_CHANNELS)) ? AW'(MAX_CHANNELS) : AW'(chan_in_use);
  assign row_ok = AW'(in_ch.read_row) < AW'(MAX_CHANNELS);
  assign col_ok = AW'(in_ch.read_col) < AW'(MAX_CHANNELS);
  assign dbl    = is_hit && full && g[0] && !g[1] && g[2];

  always_comb begin
    q_item           = '0;
    q_item.kind      = in_ch.kind;
    q_item.full      = is_hit && full;
    q_item.dbl       = dbl;
    q_item.tru       = dbl && (event_r[1] == event_r[2]);
    q_item.mult      = is_hit && full && g[0] && !g[1] && !g[2] && g[3];
    q_item.a         = dbl ? chan_r[1] : '0;
    q_item.b         = dbl ? chan_r[2] : '0;
    q_item.pair_ok   = (AW'(chan_r[1]) < act) && (AW'(chan_r[2]) < act);
    q_item.count_hit = is_hit && (AW'(in_ch.hit_channel) < act);
    q_item.ch        = in_ch.hit_channel;
    q_item.sel       = sel;
    q_item.row       = in_ch.read_row;
    q_item.col       = in_ch.read_col;
    q_item.rd_ok     = (sel == TBL_HITS) ? row_ok : (row_ok && col_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept && is_hit && (fill_r < FILL_W'(WINDOW_DEPTH))) begin
      fill_r <= fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_hit) begin
      for (int i = 0; i < WIN_HELD - 1; i++) begin
        time_r[i]  <= time_r[i+1];
        chan_r[i]  <= chan_r[i+1];
        event_r[i] <= event_r[i+1];
      end
      time_r[WIN_HELD-1]  <= in_ch.hit_time;
      chan_r[WIN_HELD-1]  <= in_ch.hit_channel;
      event_r[WIN_HELD-1] <= in_ch.hit_event;
    end
  end

endmodule

>>> hdl/csort_back.sv
// Back end: counter memories, read-modify-write pipeline, totals and result buffer.
// Depends on csort_pkg, csort_ram, csort_fifo and csort_out_if.
module csort_back import csort_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  item_t        q_item,
  output logic         q_pop,
  output back_status_t status,
  csort_out_if.source  out_ch
);

  localparam int CH_BITS    = $clog2(MAX_CHANNELS);
  localparam int HA_W       = 2 * CH_BITS;
  localparam int HITS_DEPTH = 1 << CH_BITS;
  localparam int HIST_DEPTH = 1 << HA_W;
  localparam int OCNT_W     = $clog2(OUT_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0] cnt_t;

  logic              clear_r;
  logic [HA_W-1:0]   clr_addr_r;
  logic              phase_r, phase_nxt;
  logic [BACKLOG_W-1:0] infl_r, infl_nxt;

  logic               w_valid_r, w_last_r, w_phase_r;
  item_t              w_item_r;
  logic [CH_BITS-1:0] w_hits_addr_r;
  logic [HA_W-1:0]    w_hist_addr_r;

  logic               fh_v_r, fd_v_r, ft_v_r;
  logic [CH_BITS-1:0] fh_addr_r;
  logic [HA_W-1:0]    fd_addr_r, ft_addr_r;
  cnt_t               fh_data_r, fd_data_r, ft_data_r;

  cnt_t tot_dbl_r, tot_tru_r, tot_mul_r;

  logic               need2, issue, op_last, credit_ok, push;
  logic [BACKLOG_W-1:0] backlog;
  logic [OCNT_W-1:0]  ocnt;
  logic [CH_BITS-1:0] hits_raddr, hits_waddr;
  logic [HA_W-1:0]    hist_raddr, dbl_waddr, tru_waddr;
  cnt_t               hits_rdata, dbl_rdata, tru_rdata;
  cnt_t               hits_cur, dbl_cur, tru_cur;
  cnt_t               hits_wdata, dbl_wdata, tru_wdata;
  logic               hits_we, dbl_we, tru_we;
  logic               upd, hits_upd, dbl_upd, tru_upd;
  logic [RD_W-1:0]    rd_val;
  result_t            res, head;

  function automatic logic [CH_BITS-1:0] ch_idx(input logic [CH_W-1:0] c);
    return CH_BITS'(c);
  endfunction

  function automatic cnt_t sat_inc(input cnt_t v);
    return (&v) ? v : v + COUNT_BITS'(1);
  endfunction

  // Issue: one memory op per cycle unless stalled, a second for the mirrored cell.
  assign need2     = (q_item.kind == KIND_HIT) && q_item.dbl && q_item.pair_ok &&
                     (q_item.a != q_item.b);
  assign backlog   = BACKLOG_W'(ocnt) + infl_r;
  assign credit_ok = backlog < BACKLOG_W'(OUT_DEPTH);
  assign issue     = !clear_r && q_valid && (phase_r || credit_ok);
  assign op_last   = phase_r || !need2;
  assign q_pop     = issue && op_last;
  assign phase_nxt = issue ? !op_last : phase_r;
  assign push      = w_valid_r && w_last_r;

  always_comb begin
    infl_nxt = infl_r;
    if (issue && !phase_r && !push) begin
      infl_nxt = infl_r + 1'b1;
    end else if (push && !(issue && !phase_r)) begin
      infl_nxt = infl_r - 1'b1;
    end
  end

  always_comb begin
    if (q_item.kind == KIND_READ) begin
      hits_raddr = ch_idx(q_item.row);
      hist_raddr = {ch_idx(q_item.row), ch_idx(q_item.col)};
    end else begin
      hits_raddr = ch_idx(q_item.ch);
      hist_raddr = phase_r ? {ch_idx(q_item.b), ch_idx(q_item.a)}
                           : {ch_idx(q_item.a), ch_idx(q_item.b)};
    end
  end

  // Update side: read data plus bypass of the write made in the previous cycle.
  assign hits_cur = (fh_v_r && (fh_addr_r == w_hits_addr_r)) ? fh_data_r : hits_rdata;
  assign dbl_cur  = (fd_v_r && (fd_addr_r == w_hist_addr_r)) ? fd_data_r : dbl_rdata;
  assign tru_cur  = (ft_v_r && (ft_addr_r == w_hist_addr_r)) ? ft_data_r : tru_rdata;

  assign upd      = w_valid_r && (w_item_r.kind == KIND_HIT);
  assign hits_upd = upd && !w_phase_r && w_item_r.count_hit;
  assign dbl_upd  = upd && w_item_r.dbl && w_item_r.pair_ok;
  assign tru_upd  = dbl_upd && w_item_r.tru;

  assign hits_we    = clear_r || hits_upd;
  assign hits_waddr = clear_r ? clr_addr_r[CH_BITS-1:0] : w_hits_addr_r;
  assign hits_wdata = clear_r ? '0 : sat_inc(hits_cur);
  assign dbl_we     = clear_r || dbl_upd;
  assign dbl_waddr  = clear_r ? clr_addr_r : w_hist_addr_r;
  assign dbl_wdata  = clear_r ? '0 : sat_inc(dbl_cur);
  assign tru_we     = clear_r || tru_upd;
  assign tru_waddr  = clear_r ? clr_addr_r : w_hist_addr_r;
  assign tru_wdata  = clear_r ? '0 : sat_inc(tru_cur);

  csort_ram #(.WIDTH(COUNT_BITS), .DEPTH(HITS_DEPTH)) u_hits_ram (
    .clk, .we(hits_we), .waddr(hits_waddr), .wdata(hits_wdata),
    .raddr(hits_raddr), .rdata(hits_rdata)
  );

  csort_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_DEPTH)) u_dbl_ram (
    .clk, .we(dbl_we), .waddr(dbl_waddr), .wdata(dbl_wdata),
    .raddr(hist_raddr), .rdata(dbl_rdata)
  );

  csort_ram #(.WIDTH(COUNT_BITS), .DEPTH(HIST_DEPTH)) u_tru_ram (
    .clk, .we(tru_we), .waddr(tru_waddr), .wdata(tru_wdata),
    .raddr(hist_raddr), .rdata(tru_rdata)
  );

  always_comb begin
    rd_val = '0;
    unique case (w_item_r.sel)
      TBL_HITS:   rd_val = w_item_r.rd_ok ? RD_W'(hits_cur) : '0;
      TBL_DOUBLE: rd_val = w_item_r.rd_ok ? RD_W'(dbl_cur) : '0;
      TBL_TRUE:   rd_val = w_item_r.rd_ok ? RD_W'(tru_cur) : '0;
      TBL_TOTALS: begin
        case (w_item_r.row)
          TOT_DOUBLE:   rd_val = RD_W'(tot_dbl_r);
          TOT_TRUE:     rd_val = RD_W'(tot_tru_r);
          TOT_MULTIPLE: rd_val = RD_W'(tot_mul_r);
          default:      rd_val = '0;
        endcase
      end
      default:    rd_val = '0;
    endcase
  end

  always_comb begin
    res                = '0;
    res.window_full    = w_item_r.full;
    res.double_found   = w_item_r.dbl;
    res.true_found     = w_item_r.tru;
    res.multiple_found = w_item_r.mult;
    res.pair_first     = w_item_r.a;
    res.pair_second    = w_item_r.b;
    res.read_value     = (w_item_r.kind == KIND_READ) ? rd_val : '0;
  end

  csort_fifo #(.elem_t(result_t), .DEPTH(OUT_DEPTH)) u_out_buf (
    .clk, .rst_n, .push, .din(res), .pop(out_ch.valid && out_ch.ready),
    .dout(head), .count(ocnt)
  );

  assign out_ch.valid          = (ocnt != '0);
  assign out_ch.window_full    = head.window_full;
  assign out_ch.double_found   = head.double_found;
  assign out_ch.true_found     = head.true_found;
  assign out_ch.multiple_found = head.multiple_found;
  assign out_ch.pair_first     = head.pair_first;
  assign out_ch.pair_second    = head.pair_second;
  assign out_ch.read_value     = head.read_value;

  assign status.clearing = clear_r;
  assign status.backlog  = backlog;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
      phase_r    <= 1'b0;
      infl_r     <= '0;
      w_valid_r  <= 1'b0;
      fh_v_r     <= 1'b0;
      fd_v_r     <= 1'b0;
      ft_v_r     <= 1'b0;
      tot_dbl_r  <= '0;
      tot_tru_r  <= '0;
      tot_mul_r  <= '0;
    end else begin
      if (clear_r) begin
        clr_addr_r <= clr_addr_r + 1'b1;
        if (&clr_addr_r) begin
          clear_r <= 1'b0;
        end
      end
      phase_r   <= phase_nxt;
      infl_r    <= infl_nxt;
      w_valid_r <= issue;
      fh_v_r    <= hits_we;
      fd_v_r    <= dbl_we;
      ft_v_r    <= tru_we;
      if (upd && !w_phase_r) begin
        if (w_item_r.dbl) begin
          tot_dbl_r <= sat_inc(tot_dbl_r);
        end
        if (w_item_r.tru) begin
          tot_tru_r <= sat_inc(tot_tru_r);
        end
        if (w_item_r.mult) begin
          tot_mul_r <= sat_inc(tot_mul_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      w_item_r      <= q_item;
      w_phase_r     <= phase_r;
      w_last_r      <= op_last;
      w_hits_addr_r <= hits_raddr;
      w_hist_addr_r <= hist_raddr;
    end
    fh_addr_r <= hits_waddr;
    fh_data_r <= hits_wdata;
    fd_addr_r <= dbl_waddr;
    fd_data_r <= dbl_wdata;
    ft_addr_r <= tru_waddr;
    ft_data_r <= tru_wdata;
  end

endmodule

>>> hdl/coincidence_sorter.sv
// Top level of the coincidence sorter: configuration registers, front, queue and back.
// Depends on csort_pkg, csort_ifs, csort_front, csort_fifo, csort_back and the macros.
//
//   Port group  Direction  Handshake                     Carries
//   in_ch       sink       valid/ready                   hit or counter read item
//   out_ch      source     valid/ready                   one result per item
//   cfg (APB)   slave      psel/penable/pwrite, pready   window and channel count
//
// A hit takes one operation of the counter pipeline, or two when a pair of different
// counted channels needs both mirrored histogram cells; each histogram memory does
// at most one read-modify-write per cycle. After reset the counter memories are
// cleared, one entry per cycle, over all 2**(2*clog2(MAX_CHANNELS)) histogram
// addresses (256 by default); in_ch.ready is low meanwhile.
// A four-entry queue and a four-entry result buffer let input and output stall apart.
`include "coincidence_sorter_macros.svh"

module coincidence_sorter import csort_pkg::*; #(
  parameter int MAX_CHANNELS = 16,
  parameter int COUNT_BITS   = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  csort_in_if.sink          in_ch,
  csort_out_if.source       out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [CW_W-1:0]  cw_r;
  logic [CIU_W-1:0] ciu_r;
  logic             cfg_wr;

  logic         f_push, q_pop, q_full, q_valid;
  item_t        f_item, q_item;
  logic [QCW-1:0] q_count;
  back_status_t b_status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r  <= CW_RESET;
      ciu_r <= CIU_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WINDOW:   cw_r  <= pwdata[CW_W-1:0];
        REG_CHANNELS: ciu_r <= pwdata[CIU_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW:   prdata = CFG_DW'(cw_r);
      REG_CHANNELS: prdata = CFG_DW'(ciu_r);
    endcase
  end

  csort_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
    .clk, .rst_n, .in_ch,
    .coinc_window(cw_r), .chan_in_use(ciu_r),
    .q_full, .clearing(b_status.clearing),
    .q_push(f_push), .q_item(f_item)
  );

  csort_fifo #(.elem_t(item_t), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk, .rst_n, .push(f_push), .din(f_item), .pop(q_pop),
    .dout(q_item), .count(q_count)
  );

  assign q_full  = (q_count == QCW'(QUEUE_DEPTH));
  assign q_valid = (q_count != '0);

  csort_back #(.MAX_CHANNELS(MAX_CHANNELS), .COUNT_BITS(COUNT_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_item, .q_pop, .status(b_status), .out_ch
  );

  `CS_ASSERT_ALWAYS(a_backlog_bound, clk, rst_n, b_status.backlog <= BACKLOG_W'(OUT_DEPTH), "result buffer overcommitted")
  `CS_ASSERT_IMPLY(a_no_accept_clearing, clk, rst_n, b_status.clearing, !(in_ch.valid && in_ch.ready), "item accepted during clearing pass")
  `CS_ASSERT_IMPLY(a_true_needs_double, clk, rst_n, out_ch.valid && out_ch.true_found, out_ch.double_found && out_ch.window_full, "true pair without double")
  `CS_ASSERT_IMPLY(a_queue_no_overflow, clk, rst_n, q_full, !f_push, "push into full queue")

endmodule
